/* hdl/plsim_pkg.sv */
package plsim_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_THRESHOLD_MODE  = 2'd0;
	localparam logic [1:0] REG_THRESHOLD_RATIO = 2'd1;
	localparam logic [1:0] REG_GATE_MODE       = 2'd2;
	localparam logic [1:0] REG_GATE_THRESHOLD  = 2'd3;

	// register reset values
	localparam logic [15:0] RATIO_RESET = 16'd2048;

	// fixed field widths
	localparam int SAMPLE_W = 16;
	localparam int DIFF_W   = 17;
	localparam int SCORE_W  = 16;
	localparam int REFCNT_W = 12;
	localparam int PROW_W   = 6;
	localparam int QUO_W    = 17;

	localparam logic [REFCNT_W-1:0] REF_MAX = 12'd4095;

endpackage

/* hdl/plsim_ram.sv */
module plsim_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/profile_length_similarity_top.sv */
// Profile length similarity. Samples of a row are taken one per cycle and
// stored; on the last sample of a row the block goes busy (sample_ready low)
// and works the row through a shared subtractor, multipliers and a compare:
// one pass over the row builds the circular differences, then a left and a
// right edge scan visit each difference with a read, a multiply and a
// compare step. A probe row then stores its length if the store has room.
// A reference row emits one request per stored probe row; each reads the
// stored length, runs the restoring divider (skipped when either length is
// zero) and holds its result for as long as score_ready is held low.
// Configuration registers sit at byte addresses 0, 4, 8 and 12 and should
// only be written while the block is idle.
module profile_length_similarity_top #(
	parameter int ROW_SAMPLES = 256,
	parameter int PROBE_ROWS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// sample channel
	input  logic        sample_valid,
	output logic        sample_ready,
	input  logic signed [15:0] sample,
	input  logic        is_reference,
	input  logic        row_end,
	input  logic        new_set,
	// score channel
	output logic        score_valid,
	input  logic        score_ready,
	output logic [5:0]  probe_row,
	output logic [11:0] reference_row,
	output logic [15:0] score,
	output logic        last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int LW  = $clog2(ROW_SAMPLES + 1);
	localparam int AW  = $clog2(ROW_SAMPLES);
	localparam int PAW = (PROBE_ROWS > 1) ? $clog2(PROBE_ROWS) : 1;
	localparam int PCW = $clog2(PROBE_ROWS + 1);
	localparam int SW  = plsim_pkg::DIFF_W + LW + 1;
	localparam int NW  = SW + 16;
	localparam int PW  = plsim_pkg::DIFF_W + LW;
	localparam int DW  = LW + 18;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DRD  = 4'd1;
	localparam logic [3:0] ST_DWR  = 4'd2;
	localparam logic [3:0] ST_DEND = 4'd3;
	localparam logic [3:0] ST_THR  = 4'd4;
	localparam logic [3:0] ST_SRD  = 4'd5;
	localparam logic [3:0] ST_SMUL = 4'd6;
	localparam logic [3:0] ST_SCMP = 4'd7;
	localparam logic [3:0] ST_LEN  = 4'd8;
	localparam logic [3:0] ST_PRD  = 4'd9;
	localparam logic [3:0] ST_PLD  = 4'd10;
	localparam logic [3:0] ST_DIV  = 4'd11;
	localparam logic [3:0] ST_OUT  = 4'd12;

	logic [3:0] state_q;

	// configuration registers
	logic        thr_mode_q;
	logic [15:0] thr_ratio_q;
	logic        gate_mode_q;
	logic [15:0] gate_thr_q;

	// row intake
	logic [LW-1:0] sidx_q;
	logic [LW-1:0] n_q;
	logic          isref_q;
	logic signed [15:0] first_q;
	logic signed [15:0] last_q;

	// difference pass
	logic signed [15:0] wprev_q;
	logic signed [15:0] wcur_q;
	logic [LW-1:0]      cnt_q;
	logic signed [plsim_pkg::DIFF_W-1:0] peak_q;
	logic signed [SW-1:0] sum_q;

	// edge scan
	logic [NW-1:0] num_q;
	logic [LW-1:0] kval_q;
	logic [PW-1:0] prod_q;
	logic          dir_q;
	logic [LW-1:0] left_q;

	// probe store and scoring
	logic [PCW-1:0] pcount_q;
	logic [11:0]    rcount_q;
	logic [PAW-1:0] pi_q;
	logic [LW-1:0]  len_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  dsh_q;
	logic [4:0]     bit_q;
	logic [plsim_pkg::QUO_W-1:0] quo_q;
	logic [15:0]    score_q;

	// memory ports
	logic          row_we;
	logic [AW-1:0] row_waddr;
	logic [AW-1:0] row_raddr;
	logic signed [15:0] row_rdata;
	logic          dif_we;
	logic [AW-1:0] dif_waddr;
	logic [AW-1:0] dif_raddr;
	logic signed [plsim_pkg::DIFF_W-1:0] dif_rdata;
	logic          prb_we;
	logic [PAW-1:0] prb_waddr;
	logic [LW-1:0] prb_rdata;

	// combinational helpers
	logic          in_acc;
	logic [LW-1:0] idx_eff;
	logic          idx_wr;
	logic [LW-1:0] n_next;
	logic signed [15:0] sub_a;
	logic signed [plsim_pkg::DIFF_W-1:0] diff_c;
	logic [SW-1:0] sum_mag;
	logic [SW-1:0] base_c;
	logic [plsim_pkg::DIFF_W-1:0] dmag;
	logic          hit_c;
	logic signed [LW+1:0] lens_c;
	logic [LW-1:0] len_c;
	logic          is_last;
	logic          div_ge;
	logic [plsim_pkg::QUO_W-1:0] quo_next;
	logic [LW-1:0] m_c;
	logic [LW:0]   s_c;
	logic          cfg_wr;

	plsim_ram #(.WIDTH(16), .DEPTH(ROW_SAMPLES)) u_row_ram (
		.clk(clk), .we(row_we), .waddr(row_waddr), .wdata(sample),
		.raddr(row_raddr), .rdata(row_rdata)
	);

	plsim_ram #(.WIDTH(plsim_pkg::DIFF_W), .DEPTH(ROW_SAMPLES)) u_dif_ram (
		.clk(clk), .we(dif_we), .waddr(dif_waddr), .wdata(diff_c),
		.raddr(dif_raddr), .rdata(dif_rdata)
	);

	plsim_ram #(.WIDTH(LW), .DEPTH(PROBE_ROWS)) u_prb_ram (
		.clk(clk), .we(prb_we), .waddr(prb_waddr), .wdata(len_c),
		.raddr(pi_q), .rdata(prb_rdata)
	);

	// handshakes
	assign sample_ready = (state_q == ST_IDLE);
	assign score_valid  = (state_q == ST_OUT);
	assign in_acc       = sample_valid && sample_ready;
	assign pready       = 1'b1;
	assign cfg_wr       = psel && penable && pwrite;

	// intake addressing
	assign idx_eff   = new_set ? '0 : sidx_q;
	assign idx_wr    = (idx_eff < LW'(ROW_SAMPLES));
	assign n_next    = idx_wr ? idx_eff + 1'b1 : idx_eff;
	assign row_we    = in_acc && idx_wr;
	assign row_waddr = idx_eff[AW-1:0];
	assign row_raddr = cnt_q[AW-1:0];

	// shared subtractor for the circular difference
	assign sub_a  = (state_q == ST_DWR) ? row_rdata : first_q;
	assign diff_c = plsim_pkg::DIFF_W'(sub_a) - plsim_pkg::DIFF_W'(wprev_q);
	assign dif_we    = (state_q == ST_DWR) || (state_q == ST_DEND);
	assign dif_waddr = (state_q == ST_DWR) ? AW'(cnt_q - 1'b1) : AW'(n_q - 1'b1);
	assign dif_raddr = cnt_q[AW-1:0];

	// threshold base and scan compare
	assign sum_mag = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign base_c  = thr_mode_q ? sum_mag : SW'(unsigned'(peak_q));
	assign dmag    = dif_rdata[plsim_pkg::DIFF_W-1] ? plsim_pkg::DIFF_W'(-dif_rdata)
	                                                 : plsim_pkg::DIFF_W'(dif_rdata);
	assign hit_c   = !(num_q > NW'({prod_q, 12'b0}));

	// span length, clamped at zero
	assign lens_c = signed'({2'b00, cnt_q}) - signed'({2'b00, left_q})
	                + signed'((LW+2)'(1));
	assign len_c  = (lens_c > 0) ? lens_c[LW-1:0] : '0;
	assign prb_we    = (state_q == ST_LEN) && !isref_q && (pcount_q < PCW'(PROBE_ROWS));
	assign prb_waddr = pcount_q[PAW-1:0];

	// divider step and operands
	assign m_c      = (prb_rdata < len_q) ? prb_rdata : len_q;
	assign s_c      = {1'b0, prb_rdata} + {1'b0, len_q};
	assign div_ge   = (rem_q >= dsh_q);
	assign quo_next = {quo_q[plsim_pkg::QUO_W-2:0], div_ge};
	assign is_last  = ({{(PCW-PAW){1'b0}}, pi_q} == pcount_q - 1'b1);

	// result fields
	assign probe_row     = plsim_pkg::PROW_W'(pi_q);
	assign reference_row = rcount_q;
	assign score         = score_q;
	assign last          = is_last;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_mode_q  <= 1'b0;
			thr_ratio_q <= plsim_pkg::RATIO_RESET;
			gate_mode_q <= 1'b0;
			gate_thr_q  <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				plsim_pkg::REG_THRESHOLD_MODE:  thr_mode_q  <= pwdata[0];
				plsim_pkg::REG_THRESHOLD_RATIO: thr_ratio_q <= pwdata[15:0];
				plsim_pkg::REG_GATE_MODE:       gate_mode_q <= pwdata[0];
				plsim_pkg::REG_GATE_THRESHOLD:  gate_thr_q  <= pwdata[15:0];
			endcase
		end
	end

	// configuration reads
	always_comb begin
		unique case (paddr[3:2])
			plsim_pkg::REG_THRESHOLD_MODE:  prdata = {31'b0, thr_mode_q};
			plsim_pkg::REG_THRESHOLD_RATIO: prdata = {16'b0, thr_ratio_q};
			plsim_pkg::REG_GATE_MODE:       prdata = {31'b0, gate_mode_q};
			plsim_pkg::REG_GATE_THRESHOLD:  prdata = {16'b0, gate_thr_q};
		endcase
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (row_we) begin
			last_q <= sample;
			if (idx_eff == '0) begin
				first_q <= sample;
			end
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && row_end) begin
					n_q     <= n_next;
					isref_q <= is_reference;
					wprev_q <= idx_wr ? sample : last_q;
					wcur_q  <= (idx_wr && idx_eff == '0) ? sample : first_q;
					peak_q  <= '0;
					sum_q   <= '0;
				end
			end
			ST_DWR, ST_DEND: begin
				if (diff_c > peak_q) begin
					peak_q <= diff_c;
				end
				sum_q <= sum_q + SW'(diff_c);
				if (state_q == ST_DWR) begin
					wprev_q <= wcur_q;
					wcur_q  <= row_rdata;
				end
			end
			ST_THR: begin
				num_q  <= NW'(base_c) * NW'(thr_ratio_q);
				kval_q <= thr_mode_q ? n_q : LW'(1);
			end
			ST_SMUL: prod_q <= PW'(dmag) * PW'(kval_q);
			ST_SCMP: begin
				if (!dir_q && (hit_c || cnt_q == n_q - 1'b1)) begin
					left_q <= cnt_q;
				end
			end
			ST_LEN: len_q <= len_c;
			ST_PLD: begin
				rem_q <= DW'({m_c, 17'b0}) + DW'(s_c);
				dsh_q <= DW'({s_c, 17'b0});
				bit_q <= 5'd16;
				quo_q <= '0;
				score_q <= '0;
			end
			ST_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= quo_next;
				bit_q <= bit_q - 1'b1;
				if (bit_q == '0) begin
					score_q <= (gate_mode_q && !(quo_next[15:0] > gate_thr_q)) ? '0
					                                                           : quo_next[15:0];
				end
			end
			default: ;
		endcase
	end

	// sequencer and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			sidx_q   <= '0;
			cnt_q    <= '0;
			dir_q    <= 1'b0;
			pcount_q <= '0;
			rcount_q <= '0;
			pi_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (new_set) begin
							pcount_q <= '0;
							rcount_q <= '0;
						end
						if (row_end) begin
							sidx_q  <= '0;
							cnt_q   <= LW'(1);
							state_q <= (n_next == LW'(1)) ? ST_DEND : ST_DRD;
						end else begin
							sidx_q <= n_next;
						end
					end
				end
				ST_DRD: state_q <= ST_DWR;
				ST_DWR: begin
					if (cnt_q == n_q - 1'b1) begin
						state_q <= ST_DEND;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_DRD;
					end
				end
				ST_DEND: state_q <= ST_THR;
				ST_THR: begin
					cnt_q   <= '0;
					dir_q   <= 1'b0;
					state_q <= ST_SRD;
				end
				ST_SRD:  state_q <= ST_SMUL;
				ST_SMUL: state_q <= ST_SCMP;
				ST_SCMP: begin
					if (!dir_q) begin
						if (hit_c || cnt_q == n_q - 1'b1) begin
							dir_q <= 1'b1;
							cnt_q <= n_q - 1'b1;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
						state_q <= ST_SRD;
					end else if (hit_c || cnt_q == '0) begin
						state_q <= ST_LEN;
					end else begin
						cnt_q   <= cnt_q - 1'b1;
						state_q <= ST_SRD;
					end
				end
				ST_LEN: begin
					if (!isref_q) begin
						if (pcount_q < PCW'(PROBE_ROWS)) begin
							pcount_q <= pcount_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (pcount_q == '0) begin
						if (rcount_q < plsim_pkg::REF_MAX) begin
							rcount_q <= rcount_q + 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						pi_q    <= '0;
						state_q <= ST_PRD;
					end
				end
				ST_PRD: state_q <= ST_PLD;
				ST_PLD: begin
					state_q <= (prb_rdata == '0 || len_q == '0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (bit_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (score_ready) begin
						if (is_last) begin
							if (rcount_q < plsim_pkg::REF_MAX) begin
								rcount_q <= rcount_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end else begin
							pi_q    <= pi_q + 1'b1;
							state_q <= ST_PRD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stored probe rows never exceed the store
	assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= PCW'(PROBE_ROWS))
		else $error("probe count beyond store depth");

	// a score never exceeds one in q1.15
	assert property (@(posedge clk) disable iff (!arst_n)
		score_valid |-> (score <= 16'd32768))
		else $error("score above one");

	// the final request of a row returns the block to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(score_valid && score_ready && last) |=> sample_ready)
		else $error("block not idle after final request");

	// the divider runs at most seventeen steps
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (bit_q <= 5'd16))
		else $error("divider step count out of range");

endmodule

/* sim/profile_length_similarity_checker.sv */
module profile_length_similarity_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	input  logic        sample_ready,
	input  logic signed [15:0] sample,
	input  logic        is_reference,
	input  logic        row_end,
	input  logic        new_set,
	input  logic        score_valid,
	input  logic        score_ready,
	input  logic [5:0]  probe_row,
	input  logic [11:0] reference_row,
	input  logic [15:0] score,
	input  logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          pending
);

	localparam int ROWS_MAX   = 256;
	localparam int PROBES_MAX = 64;

	typedef struct packed {
		logic [5:0]  prow;
		logic [11:0] rrow;
		logic [15:0] val;
		logic        fin;
	} score_rec_t;

	score_rec_t scores_due[$];

	// own copy of the block state
	int          row_buf[ROWS_MAX];
	logic [9:0]  probe_len[PROBES_MAX];
	int          fill;
	int          probes;
	logic [11:0] refs;
	logic        thr_mode;
	logic [15:0] thr_ratio;
	logic        gate_on;
	logic [15:0] gate_thr;

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		fails++;
	endtask

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	// edge scans over the stored row of n samples
	function automatic logic [9:0] span_len(int n);
		int d[ROWS_MAX];
		longint peak, total, left, right, len;
		longint unsigned num, k;
		int nx, pv;
		peak = 0;
		total = 0;
		if (n == 0) return 0;
		for (int j = 0; j < n; j++) begin
			nx = (j + 1 == n) ? 0 : j + 1;
			pv = (j == 0) ? n - 1 : j - 1;
			d[j] = row_buf[nx] - row_buf[pv];
			if (d[j] > peak) peak = d[j];
			total += d[j];
		end
		if (!thr_mode) begin
			num = longint'(peak) * thr_ratio;
			k = 1;
		end else begin
			num = magnitude(total) * thr_ratio;
			k = n;
		end
		left = n - 1;
		for (int j = 0; j < n; j++) begin
			if (!(num > magnitude(d[j]) * 4096 * k)) begin
				left = j;
				break;
			end
		end
		right = 0;
		for (int j = n; j > 0; j--) begin
			if (!(num > magnitude(d[j-1]) * 4096 * k)) begin
				right = j - 1;
				break;
			end
		end
		len = right - left + 1;
		return (len > 0) ? len[9:0] : 10'd0;
	endfunction

	// predict on every accepted request, compare every accepted score
	always @(posedge clk or negedge arst_n) begin
		score_rec_t want, rec;
		logic [9:0] len;
		longint unsigned m, s, q;
		int n;
		if (!arst_n) begin
			fails = 0;
			fill = 0;
			probes = 0;
			refs = '0;
			thr_mode = 1'b0;
			thr_ratio = plsim_pkg::RATIO_RESET;
			gate_on = 1'b0;
			gate_thr = '0;
			scores_due.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					plsim_pkg::REG_THRESHOLD_MODE:  thr_mode = pwdata[0];
					plsim_pkg::REG_THRESHOLD_RATIO: thr_ratio = pwdata[15:0];
					plsim_pkg::REG_GATE_MODE:       gate_on = pwdata[0];
					plsim_pkg::REG_GATE_THRESHOLD:  gate_thr = pwdata[15:0];
				endcase
			end
			if (sample_valid && sample_ready) begin
				if (new_set) begin
					probes = 0;
					refs = '0;
					fill = 0;
				end
				if (fill < ROWS_MAX) begin
					row_buf[fill] = sample;
					fill++;
				end
				if (row_end) begin
					n = fill;
					fill = 0;
					len = span_len(n);
					if (!is_reference) begin
						if (probes < PROBES_MAX) begin
							probe_len[probes] = len;
							probes++;
						end
					end else begin
						for (int i = 0; i < probes; i++) begin
							q = 0;
							if (probe_len[i] != 0 && len != 0) begin
								m = (probe_len[i] < len) ? probe_len[i] : len;
								s = probe_len[i] + len;
								q = (m * 131072 + s) / (2 * s);
							end
							if (gate_on && !(q > gate_thr)) q = 0;
							rec.prow = i[5:0];
							rec.rrow = refs;
							rec.val = q[15:0];
							rec.fin = (i + 1 == probes);
							scores_due.push_back(rec);
						end
						if (refs < plsim_pkg::REF_MAX) refs++;
					end
				end
			end
			if (score_valid && score_ready) begin
				if (scores_due.size() == 0) begin
					report("unexpected score", score, 0);
				end else begin
					want = scores_due.pop_front();
					if (probe_row != want.prow) report("probe_row", probe_row, want.prow);
					if (reference_row != want.rrow)
						report("reference_row", reference_row, want.rrow);
					if (score != want.val) report("score", score, want.val);
					if (last != want.fin) report("last", last, want.fin);
				end
			end
		end
		pending = scores_due.size();
	end

endmodule

/* sim/tb_profile_length_similarity_top.sv */
module tb_profile_length_similarity_top;

	localparam int STALL_LIMIT = 30000;
	localparam int DRAIN_CYCLES = 2500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [15:0] sample = '0;
	logic is_reference = 1'b0;
	logic row_end = 1'b0;
	logic new_set = 1'b0;
	logic score_valid;
	logic score_ready = 1'b0;
	logic [5:0] probe_row;
	logic [11:0] reference_row;
	logic [15:0] score;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	int fails;
	int pending;
	int tx_idle = 0;
	int rx_stall = 0;
	int sent = 0;
	int quiet = 0;

	always #5 clk = ~clk;

	profile_length_similarity_top dut (.*);

	profile_length_similarity_checker chk (.*);

	// receiver back-pressure
	always @(posedge clk) score_ready <= ($urandom_range(99) >= rx_stall);

	// watchdog on cycles with no accepted request, score or register access
	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (score_valid && score_ready) || psel) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(logic signed [15:0] s, logic ref_f, logic end_f, logic ns);
		if ($urandom_range(99) < tx_idle) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle);
		end
		sample_valid <= 1'b1;
		sample <= s;
		is_reference <= ref_f;
		row_end <= end_f;
		new_set <= ns;
		do @(posedge clk); while (!sample_ready);
		sent++;
	endtask

	// shape 0 plateau, 1 noise, 2 plateau with mixed-kind samples before the last
	task automatic send_row(logic ref_f, int n, logic ns, int shape);
		int lo, hi, base, amp;
		logic signed [15:0] v;
		logic kind;
		lo = $urandom_range(n - 1);
		hi = $urandom_range(n - 1, lo);
		base = $urandom_range(2000) - 1000;
		amp = $urandom_range(30000);
		for (int j = 0; j < n; j++) begin
			if (shape == 1) v = 16'($urandom);
			else v = 16'(base + ((j >= lo && j <= hi) ? amp : 0) + $urandom_range(200) - 100);
			kind = (shape == 2 && j != n - 1) ? logic'($urandom_range(1)) : ref_f;
			send(v, kind, j == n - 1, ns && j == 0);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(logic m, logic [15:0] r, logic g, logic [15:0] t);
		settle();
		write_reg(plsim_pkg::REG_THRESHOLD_MODE, 32'(m));
		write_reg(plsim_pkg::REG_THRESHOLD_RATIO, 32'(r));
		write_reg(plsim_pkg::REG_GATE_MODE, 32'(g));
		write_reg(plsim_pkg::REG_GATE_THRESHOLD, 32'(t));
	endtask

	// random sets: mostly probes then references, some noise
	task automatic random_sets(int count);
		int stop, nprobe, nref, len;
		stop = sent + count;
		while (sent < stop) begin
			nprobe = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 3);
			nref = $urandom_range(1, 2);
			for (int p = 0; p < nprobe; p++) begin
				len = $urandom_range(1, 4);
				send_row(1'b0, len, p == 0, ($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
			end
			for (int r = 0; r < nref; r++) begin
				len = $urandom_range(1, 4);
				send_row(1'b1, len, nprobe == 0 && r == 0,
					($urandom_range(7) == 0) ? $urandom_range(1, 2) : 0);
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset settings
		tx_idle = 17;
		rx_stall = 81;
		set_regs(1'b0, plsim_pkg::RATIO_RESET, 1'b0, 16'd0);
		send(16'sh7fff, 1'b0, 1'b1, 1'b1);
		send(-16'sd32768, 1'b0, 1'b0, 1'b0);
		send(16'sh7fff, 1'b0, 1'b1, 1'b0);
		send(-16'sd32768, 1'b0, 1'b0, 1'b0);
		send(16'sh7fff, 1'b0, 1'b0, 1'b0);
		send(16'sd0, 1'b0, 1'b1, 1'b0);
		send_row(1'b0, 5, 1'b0, 0);
		send_row(1'b1, 6, 1'b0, 2);
		// more probe rows than the store holds
		for (int p = 0; p < 65; p++) send(16'(p * 997), 1'b0, 1'b1, p == 0);
		send_row(1'b1, 2, 1'b0, 0);

		random_sets(4);
		set_regs(1'b1, 16'd4096, 1'b1, 16'd16384);
		random_sets(4);

		tx_idle = 81;
		rx_stall = 17;
		set_regs(1'b0, 16'hffff, 1'b1, 16'd32768);
		random_sets(4);
		set_regs(1'b1, 16'd0, 1'b0, 16'd0);
		random_sets(4);

		tx_idle = 0;
		rx_stall = 0;
		set_regs(1'b0, 16'd1, 1'b1, 16'd0);
		random_sets(4);
		set_regs(1'b1, 16'hffff, 1'b0, 16'd32768);
		random_sets(4);

		settle();
		if (fails == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
